/* rtl/tmr_pkg.sv */
package tmr_pkg;

  // Field widths that the interface fixes.
  localparam int CODE_W     = 5;
  localparam int KEY_IDX_W  = 2;
  localparam int DELAY_W    = 10;
  localparam int IVL_W      = 9;
  localparam int DCODE_W    = 2;
  localparam int SCODE_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int MAX_LANES  = 3;

  // Virtual key codes.
  localparam logic [CODE_W-1:0] CODE_SHIFT = 5'd16;
  localparam logic [CODE_W-1:0] CODE_CTRL  = 5'd17;
  localparam logic [CODE_W-1:0] CODE_ALT   = 5'd18;

  // Lane order: Alt, Ctrl, Shift.
  localparam logic [KEY_IDX_W-1:0] KEY_ALT   = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_CTRL  = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_SHIFT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd2;

  // Control for one key lane for the word being accepted.
  typedef struct packed {
    logic take;
    logic clear;
    logic down;
  } tmr_lane_ctl_t;

  // Key code of a lane.
  function automatic logic [CODE_W-1:0] key_code_of(input logic [KEY_IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    case (idx)
      KEY_ALT:   code = CODE_ALT;
      KEY_CTRL:  code = CODE_CTRL;
      KEY_SHIFT: code = CODE_SHIFT;
      default:   code = CODE_SHIFT;
    endcase
    return code;
  endfunction

  // Initial delay, (code + 1) * 250 ms.
  function automatic logic [DELAY_W-1:0] delay_ms(input logic [DCODE_W-1:0] code);
    logic [DELAY_W-1:0] d;
    case (code)
      2'd0:    d = 10'd250;
      2'd1:    d = 10'd500;
      2'd2:    d = 10'd750;
      default: d = 10'd1000;
    endcase
    return d;
  endfunction

  // Repeat interval in ms for each speed code.
  function automatic logic [IVL_W-1:0] interval_ms(input logic [SCODE_W-1:0] code);
    logic [IVL_W-1:0] v;
    case (code)
      5'd0:  v = 9'd400;
      5'd1:  v = 9'd295;
      5'd2:  v = 9'd233;
      5'd3:  v = 9'd193;
      5'd4:  v = 9'd165;
      5'd5:  v = 9'd144;
      5'd6:  v = 9'd127;
      5'd7:  v = 9'd114;
      5'd8:  v = 9'd104;
      5'd9:  v = 9'd95;
      5'd10: v = 9'd87;
      5'd11: v = 9'd81;
      5'd12: v = 9'd76;
      5'd13: v = 9'd71;
      5'd14: v = 9'd67;
      5'd15: v = 9'd63;
      5'd16: v = 9'd59;
      5'd17: v = 9'd56;
      5'd18: v = 9'd54;
      5'd19: v = 9'd51;
      5'd20: v = 9'd49;
      5'd21: v = 9'd47;
      5'd22: v = 9'd45;
      5'd23: v = 9'd43;
      5'd24: v = 9'd42;
      5'd25: v = 9'd40;
      5'd26: v = 9'd39;
      5'd27: v = 9'd37;
      5'd28: v = 9'd36;
      5'd29: v = 9'd35;
      5'd30: v = 9'd34;
      default: v = 9'd33;
    endcase
    return v;
  endfunction

endpackage

/* rtl/typematic_modifier_repeat_unit.sv */
// Typematic repeat generator for the Alt, Ctrl and Shift modifier keys.
// Input channel (in_valid / in_stall): one word is one time sample with a
// millisecond timestamp, the three key levels and a focus flag.
// Output channel (out_valid / out_stall): one word per repeat, carrying the
// key code, the system-key flag and a last flag on the final repeat of a
// sample. Repeats of one sample leave in the order Alt, Ctrl, Shift.
// Config channel (cfg_valid / cfg_ready): always ready; index 0 is the enable,
// 1 the delay code, 2 the speed code. Write only while the block is idle.
// Each key has its own lane that updates its state when a sample is taken;
// the merge stage then serializes the lanes that fired.
// The repeats of a taken sample are registered in the pending set and then
// issued through the output register, one per cycle while out_stall is low.
// Samples are taken every cycle when none repeat; a sample with repeats keeps
// the merge stage busy until its last repeat has left the pending set, and
// the next sample is taken only once the merge stage is no longer busy.
// in_stall is high while the merge stage still holds repeats of a sample.
// Reset clears all key states, empties the output and loads the enable as 1,
// delay code 1 and speed code 25. While out_stall is high the output word
// holds and the pending repeats wait; key timing is unaffected.
module typematic_modifier_repeat_unit
  import tmr_pkg::*;
#(
  parameter int TIME_BITS = 32,
  parameter int KEY_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_BITS-1:0]  in_now_ms,
  input  logic                  in_alt_down,
  input  logic                  in_ctrl_down,
  input  logic                  in_shift_down,
  input  logic                  in_in_focus,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CODE_W-1:0]     out_key_code,
  output logic                  out_system_key,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Keys beyond Shift have no input and never fire, so they get no lane.
  localparam int LANES = (KEY_COUNT < MAX_LANES) ? KEY_COUNT : MAX_LANES;

  logic               enable_r;
  logic [DCODE_W-1:0] dcode_r;
  logic [SCODE_W-1:0] scode_r;
  logic               take;
  logic               clear;
  logic [MAX_LANES-1:0] down_vec;
  logic [LANES-1:0]   fire;
  logic [DELAY_W-1:0] delay;
  logic [IVL_W-1:0]   interval;
  logic               busy;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      dcode_r  <= 2'd1;
      scode_r  <= 5'd25;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE: enable_r <= cfg_wdata[0];
        REG_DELAY:  dcode_r  <= cfg_wdata[DCODE_W-1:0];
        REG_SPEED:  scode_r  <= cfg_wdata[SCODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign delay    = delay_ms(dcode_r);
  assign interval = interval_ms(scode_r);

  // Sample handshake and the common clear condition.
  assign in_stall = busy;
  assign take     = in_valid && !busy;
  assign clear    = !enable_r || !in_in_focus;
  assign down_vec = {in_shift_down, in_ctrl_down, in_alt_down};

  // One lane per key.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tmr_lane_ctl_t ctl;
    assign ctl.take  = take;
    assign ctl.clear = clear;
    assign ctl.down  = down_vec[g];

    tmr_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .now     (in_now_ms),
      .delay   (delay),
      .interval(interval),
      .fire    (fire[g])
    );
  end

  // Serialize the repeats of a sample onto the output.
  tmr_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .fire          (fire),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key_code  (out_key_code),
    .out_system_key(out_system_key),
    .out_last      (out_last)
  );

  // While repeats are pending, the output is valid in the next cycle.
  a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("pending repeats did not reach the output");

  // A word that is not the last of its sample leaves more repeats pending.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-last word without pending repeats");

  // A sample taken while disabled produces no repeat.
  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !enable_r) |=> !busy)
    else $error("repeat produced while disabled");

  // Only Alt is sent as a system key.
  a_system_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_system_key) |-> (out_key_code == CODE_ALT))
    else $error("system key flag on a key other than Alt");

endmodule

/* rtl/tmr_lane.sv */
module tmr_lane
  import tmr_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmr_lane_ctl_t        ctl,
  input  logic [TIME_BITS-1:0] now,
  input  logic [DELAY_W-1:0]   delay,
  input  logic [IVL_W-1:0]     interval,
  output logic                 fire
);

  logic                 held_r, held_nxt;
  logic [TIME_BITS-1:0] press_r, press_nxt;
  logic [TIME_BITS-1:0] rep_r, rep_nxt;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_rep;

  // Elapsed times wrap with the timestamp width.
  assign since_press = now - press_r;
  assign since_rep   = now - rep_r;

  assign fire = ctl.take && !ctl.clear && ctl.down && held_r &&
                (since_press >= TIME_BITS'(delay)) &&
                (since_rep >= TIME_BITS'(interval));

  // Key state update for the accepted word.
  always_comb begin
    held_nxt  = held_r;
    press_nxt = press_r;
    rep_nxt   = rep_r;
    if (ctl.take) begin
      if (ctl.clear || !ctl.down) begin
        held_nxt = 1'b0;
      end else if (!held_r) begin
        held_nxt  = 1'b1;
        press_nxt = now;
        rep_nxt   = now;
      end else if (fire) begin
        rep_nxt = now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // Times are only read while the key is held, so they need no reset.
  always_ff @(posedge clk) begin
    press_r <= press_nxt;
    rep_r   <= rep_nxt;
  end

endmodule

/* rtl/tmr_merge.sv */
module tmr_merge
  import tmr_pkg::*;
#(
  parameter int LANES = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [LANES-1:0]  fire,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_key_code,
  output logic              out_system_key,
  output logic              out_last
);

  logic [LANES-1:0]  pend_r, pend_nxt;
  logic [LANES-1:0]  low;
  logic              valid_r, valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              sys_r, sys_nxt;
  logic              last_r, last_nxt;
  logic              adv;

  // Lanes still waiting hold off the next word.
  assign busy = (pend_r != '0);
  assign adv  = !valid_r || !out_stall;
  assign low  = pend_r & (~pend_r + LANES'(1));

  // Issue the lowest pending lane, one word per cycle unless out_stall holds the output.
  always_comb begin
    pend_nxt  = pend_r;
    valid_nxt = valid_r;
    code_nxt  = code_r;
    sys_nxt   = sys_r;
    last_nxt  = last_r;
    if (adv) begin
      valid_nxt = busy;
      if (busy) begin
        pend_nxt = pend_r & ~low;
        last_nxt = ((pend_r & ~low) == '0);
        for (int i = 0; i < LANES; i++) begin
          if (low[i]) begin
            code_nxt = key_code_of(KEY_IDX_W'(i));
            sys_nxt  = (key_code_of(KEY_IDX_W'(i)) == CODE_ALT);
          end
        end
      end
    end
    if (take) begin
      pend_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    sys_r  <= sys_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_key_code   = code_r;
  assign out_system_key = sys_r;
  assign out_last       = last_r;

endmodule
